@@ src/olad_pkg.sv @@
// Shared constants, codes and cell control type for the ordered list block.
`default_nettype none

package olad_pkg;

  // Payload widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  // Default number of list cells
  localparam int unsigned DEFAULT_CAPACITY = 16;

  // Operation codes
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Command broadcast to every cell for one transaction
  typedef struct packed {
    logic                     append_en;
    logic                     delete_en;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage : olad_pkg

`default_nettype wire

@@ src/olad_cell.sv @@
// One list cell: holds an entry and its occupied flag, compares and shifts.
`default_nettype none

module olad_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  olad_pkg::cell_cmd_t             cmd_i,
  input  wire                             prev_occ_i,
  input  wire                             seen_i,
  input  wire                             next_occ_i,
  input  wire  signed [olad_pkg::DATA_W-1:0] next_entry_i,
  output logic                            occ_o,
  output logic                            seen_o,
  output logic signed [olad_pkg::DATA_W-1:0] entry_o
);
  import olad_pkg::*;

  logic                     occ_q;
  logic signed [DATA_W-1:0] entry_q;
  logic                     hit;
  logic                     take_value;
  logic                     take_next;

  // Match this cell if occupied and equal; pass the first-match flag on
  assign hit    = occ_q & (entry_q == cmd_i.value);
  assign seen_o = seen_i | hit;

  // Append lands in the first free cell; delete closes up behind the match
  assign take_value = cmd_i.append_en & ~occ_q & prev_occ_i;
  assign take_next  = cmd_i.delete_en & seen_o;

  // Hold occupied flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (take_value) begin
      occ_q <= 1'b1;
    end else if (take_next) begin
      occ_q <= next_occ_i;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    if (take_value) begin
      entry_q <= cmd_i.value;
    end else if (take_next) begin
      entry_q <= next_entry_i;
    end
  end

  assign occ_o   = occ_q;
  assign entry_o = entry_q;

endmodule : olad_cell

`default_nettype wire

@@ src/ordered_list_append_delete.sv @@
// Top level: ordered list with append at tail and delete of first match.
//
//  channel  | ports                              | direction | marker
//  ---------+------------------------------------+-----------+-------------------
//  request  | func_i, value_i                    | in        | start_i & !busy_o
//  result   | status_o, entry_count_o            | out       | done_o (one cycle)
//
// On a request every cell compares its entry with value_i at once, the
// first-match flag ripples down the row of CAPACITY cells, and the cells
// shift or load on the accepting edge. The result appears on the next
// cycle with done_o high for exactly that cycle. busy_o stays low, so a new
// request may be accepted every cycle. Reset clears the occupied flags and the
// count; the list is empty right after reset. The receiver cannot stall.
`default_nettype none

module ordered_list_append_delete #(
  parameter int unsigned CAPACITY = olad_pkg::DEFAULT_CAPACITY
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  output logic                               busy_o,
  input  wire                                func_i,
  input  wire  signed [olad_pkg::DATA_W-1:0] value_i,
  output logic                               done_o,
  output logic [olad_pkg::STAT_W-1:0]        status_o,
  output logic [olad_pkg::COUNT_W-1:0]       entry_count_o
);
  import olad_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  cell_cmd_t                cmd;
  logic                     accept;
  logic [CAPACITY-1:0]      occ;
  logic [CAPACITY-1:0]      seen;
  logic [CAPACITY-1:0]      prev_occ;
  logic [CAPACITY-1:0]      seen_in;
  logic [CAPACITY-1:0]      next_occ;
  logic signed [DATA_W-1:0] entry      [CAPACITY];
  logic signed [DATA_W-1:0] next_entry [CAPACITY];
  logic                     full;
  logic                     found;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_d;
  logic [STAT_W-1:0]        status_d;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic                     done_q;
  logic [STAT_W-1:0]        status_q;
  logic [COUNT_W-1:0]       entry_count_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Broadcast the transaction to the cells
  assign cmd.append_en = accept & (func_i == FUNC_APPEND);
  assign cmd.delete_en = accept & (func_i == FUNC_DELETE);
  assign cmd.value     = value_i;

  // Wire neighbors: head sees an occupied predecessor, tail a free successor
  always_comb begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        prev_occ[i] = 1'b1;
        seen_in[i]  = 1'b0;
      end else begin
        prev_occ[i] = occ[i-1];
        seen_in[i]  = seen[i-1];
      end
      if (i == CAPACITY - 1) begin
        next_occ[i]   = 1'b0;
        next_entry[i] = '0;
      end else begin
        next_occ[i]   = occ[i+1];
        next_entry[i] = entry[i+1];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    olad_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_occ_i   (prev_occ[g]),
      .seen_i       (seen_in[g]),
      .next_occ_i   (next_occ[g]),
      .next_entry_i (next_entry[g]),
      .occ_o        (occ[g]),
      .seen_o       (seen[g]),
      .entry_o      (entry[g])
    );
  end

  assign full  = occ[CAPACITY-1];
  assign found = seen[CAPACITY-1];

  // Work out status and the new count
  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    if (func_i == FUNC_APPEND) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (found) begin
        count_d = count_q - CNT_W'(1);
      end else begin
        status_d = ST_MISS;
      end
    end
  end

  // Fit the count to the result field
  assign count_ext = {{COUNT_W{1'b0}}, count_d};

  // Hold count and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      entry_count_q <= count_ext[COUNT_W-1:0];
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;

endmodule : ordered_list_append_delete

`default_nettype wire

@@ tb/tb_ordered_list_append_delete.sv @@
// Testbench for the ordered list block: directed and random append/delete traffic.
`default_nettype none

module tb_ordered_list_append_delete;
  import olad_pkg::*;

  localparam int unsigned LIST_DEPTH = DEFAULT_CAPACITY;
  localparam int unsigned POOL_SIZE  = 6;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } list_result_t;

  // Shadow of the list contents; predicts the answer to each request
  class list_shadow;
    logic signed [DATA_W-1:0] held_values[$];
    list_result_t             expected_results[$];
    int unsigned              failures;

    function void note_request(logic op, logic signed [DATA_W-1:0] operand);
      list_result_t res;
      int           hit;
      hit = -1;
      if (op == FUNC_APPEND) begin
        if (held_values.size() >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_values.push_back(operand);
          res.status = ST_OK;
        end
      end else begin
        // remove only the first match from the head
        foreach (held_values[i]) begin
          if (hit < 0 && held_values[i] == operand) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_MISS;
        end else begin
          held_values.delete(hit);
          res.status = ST_OK;
        end
      end
      res.entry_count = COUNT_W'(held_values.size());
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [COUNT_W-1:0] entry_count);
      list_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result with no request waiting: status=%0d entry_count=%0d",
               status, entry_count);
        failures++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (status !== exp_res.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
        failures++;
      end
      if (entry_count !== exp_res.entry_count) begin
        $error("entry_count mismatch: expected %0d, actual %0d",
               exp_res.entry_count, entry_count);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     func_i = FUNC_APPEND;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [STAT_W-1:0]        status_o;
  logic [COUNT_W-1:0]       entry_count_o;

  list_shadow shadow = new();

  ordered_list_append_delete uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Check finished transactions, then record the one accepted on this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) shadow.check_result(status_o, entry_count_o);
      if (start_i && !busy_o) shadow.note_request(func_i, value_i);
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic op, input logic signed [DATA_W-1:0] operand);
    start_i <= 1'b1;
    func_i  <= op;
    value_i <= operand;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Drop start for a number of cycles
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold off until every request has been answered
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [DATA_W-1:0] pool[POOL_SIZE];
    logic                     op;
    logic signed [DATA_W-1:0] operand;
    int                       append_pct;
    bit                       quiet;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extremes, head delete, duplicates, miss, full, tail
    send_request(FUNC_DELETE, 32'sd5);
    send_request(FUNC_APPEND, 32'sh8000_0000);
    send_request(FUNC_APPEND, 32'sh7fff_ffff);
    send_request(FUNC_APPEND, -32'sd1);
    send_request(FUNC_APPEND, 32'sd7);
    send_request(FUNC_APPEND, 32'sd7);
    send_request(FUNC_DELETE, 32'sh8000_0000);
    send_request(FUNC_DELETE, 32'sd7);
    send_request(FUNC_DELETE, 32'sd12345);
    for (int k = 0; k < 13; k++) send_request(FUNC_APPEND, 32'sd100 + k);
    send_request(FUNC_APPEND, 32'sd0);
    send_request(FUNC_DELETE, 32'sd112);
    drain_results();

    // Random: phases with an append bias so the list swings between empty and full
    for (int phase = 0; phase < 35; phase++) begin
      case ($urandom_range(0, 2))
        0:       append_pct = 25;
        1:       append_pct = 50;
        default: append_pct = 85;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      foreach (pool[i]) pool[i] = random_operand();
      for (int n = 0; n < 50; n++) begin
        op = ($urandom_range(0, 99) < append_pct) ? FUNC_APPEND : FUNC_DELETE;
        if ($urandom_range(0, 4) != 0) operand = pool[$urandom_range(0, POOL_SIZE - 1)];
        else operand = random_operand();
        send_request(op, operand);
        if (!quiet) pause_sender(pick_gap());
      end
      if (phase == 17) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (shadow.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/olad_pkg.sv
src/olad_cell.sv
src/ordered_list_append_delete.sv
tb/tb_ordered_list_append_delete.sv
